// File: hw/rtl/msgpack_structure_walker_top_macros.svh
// Assertion shorthands for the structure walker.
`ifndef MSGPACK_STRUCTURE_WALKER_TOP_MACROS_SVH
`define MSGPACK_STRUCTURE_WALKER_TOP_MACROS_SVH

`ifndef SYNTH
`define MSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSW_ASSERT(lbl, prop, msg)
`define MSW_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/msw_pkg.sv
package msw_pkg;

  localparam int MAX_NESTING = 8;
  localparam int LVL_W = $clog2(MAX_NESTING + 1);
  localparam int IDX_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int STK_W = 17;

  localparam logic [1:0] ROLE_TYPE    = 2'd0;
  localparam logic [1:0] ROLE_EXT     = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_EXT  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  localparam logic [3:0] T_INVALID = 4'd0;
  localparam logic [3:0] T_NIL     = 4'd1;
  localparam logic [3:0] T_FALSE   = 4'd2;
  localparam logic [3:0] T_TRUE    = 4'd3;
  localparam logic [3:0] T_UINT    = 4'd4;
  localparam logic [3:0] T_INT     = 4'd5;
  localparam logic [3:0] T_STR     = 4'd6;
  localparam logic [3:0] T_ARR     = 4'd7;
  localparam logic [3:0] T_MAP     = 4'd8;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_TRUNC   = 2'd2;
  localparam logic [1:0] ERR_DEEP    = 2'd3;

  localparam logic [7:0] CODE_NIL     = 8'hC0;
  localparam logic [7:0] CODE_FALSE   = 8'hC2;
  localparam logic [7:0] CODE_TRUE    = 8'hC3;
  localparam logic [7:0] CODE_BIN8    = 8'hC4;
  localparam logic [7:0] CODE_UINT8   = 8'hCC;
  localparam logic [7:0] CODE_UINT16  = 8'hCD;
  localparam logic [7:0] CODE_UINT32  = 8'hCE;
  localparam logic [7:0] CODE_INT8    = 8'hD0;
  localparam logic [7:0] CODE_INT16   = 8'hD1;
  localparam logic [7:0] CODE_INT32   = 8'hD2;
  localparam logic [7:0] CODE_STR8    = 8'hD9;
  localparam logic [7:0] CODE_ARRAY16 = 8'hDC;
  localparam logic [7:0] CODE_MAP16   = 8'hDE;

  localparam logic [7:0] MASK_TOP3 = 8'hE0;
  localparam logic [7:0] MASK_TOP4 = 8'hF0;
  localparam logic [7:0] PFX_NEGFIX = 8'hE0;
  localparam logic [7:0] PFX_FIXSTR = 8'hA0;
  localparam logic [7:0] PFX_FIXARR = 8'h90;
  localparam logic [7:0] PFX_FIXMAP = 8'h80;

  typedef struct packed {
    logic [3:0]  t;
    logic [15:0] n;
    logic [1:0]  ext;
  } type_info_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [3:0]  elem_type;
    logic [15:0] elem_count;
    logic [3:0]  nest_depth;
    logic        header_done;
    logic [3:0]  levels_closed;
    logic [31:0] uint_value;
    logic        uint_valid;
    logic [1:0]  error_code;
    logic        message_done;
  } result_t;

  function automatic type_info_t decode_type(input logic [7:0] b);
    type_info_t r;
    r = '0;
    if (!b[7]) begin
      r.t = T_UINT;
    end else if ((b & MASK_TOP3) == PFX_NEGFIX) begin
      r.t = T_INT;
    end else if ((b & MASK_TOP3) == PFX_FIXSTR) begin
      r.t = T_STR;
      r.n = {11'd0, b[4:0]};
    end else if ((b & MASK_TOP4) == PFX_FIXARR) begin
      r.t = T_ARR;
      r.n = {12'd0, b[3:0]};
    end else if ((b & MASK_TOP4) == PFX_FIXMAP) begin
      r.t = T_MAP;
      r.n = {12'd0, b[3:0]};
    end else begin
      unique case (b) inside
        CODE_NIL:              r.t = T_NIL;
        CODE_FALSE:            r.t = T_FALSE;
        CODE_TRUE:             r.t = T_TRUE;
        CODE_UINT8:  begin r.t = T_UINT; r.n = 16'd1; end
        CODE_UINT16: begin r.t = T_UINT; r.n = 16'd2; end
        CODE_UINT32: begin r.t = T_UINT; r.n = 16'd4; end
        CODE_INT8:   begin r.t = T_INT;  r.n = 16'd1; end
        CODE_INT16:  begin r.t = T_INT;  r.n = 16'd2; end
        CODE_INT32:  begin r.t = T_INT;  r.n = 16'd4; end
        CODE_STR8, CODE_BIN8: begin r.t = T_STR; r.ext = 2'd1; end
        CODE_ARRAY16: begin r.t = T_ARR; r.ext = 2'd2; end
        CODE_MAP16:   begin r.t = T_MAP; r.ext = 2'd2; end
        default:      r.t = T_INVALID;
      endcase
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/msw_stream_if.sv
interface msw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [3:0]  elem_type;
  logic [15:0] elem_count;
  logic [3:0]  nest_depth;
  logic        header_done;
  logic [3:0]  levels_closed;
  logic [31:0] uint_value;
  logic        uint_valid;
  logic [1:0]  error_code;
  logic        message_done;

  modport source (
    output valid, output byte_role, output elem_type, output elem_count,
    output nest_depth, output header_done, output levels_closed,
    output uint_value, output uint_valid, output error_code, output message_done,
    input ready
  );
  modport sink (
    input valid, input byte_role, input elem_type, input elem_count,
    input nest_depth, input header_done, input levels_closed,
    input uint_value, input uint_valid, input error_code, input message_done,
    output ready
  );
endinterface

// File: hw/rtl/msgpack_structure_walker_top.sv
// Each byte's result is registered when the byte is accepted. Throughput: one byte
// per cycle unless result_ch stalls; decode, stack update and closing of up to
// MAX_NESTING levels all happen in the single stage before the result register.
// Reset: synchronous rst clears the walker state and the result valid flag;
// the child-count stack is not cleared and is only read below the current level.
`include "msgpack_structure_walker_top_macros.svh"

module msgpack_structure_walker_top (
  input logic       clk,
  input logic       rst,
  msw_in_if.sink    byte_ch,
  msw_out_if.source result_ch
);
  import msw_pkg::*;

  logic [LVL_W-1:0] stack_level, stack_level_next;
  logic [1:0]       phase, phase_next;
  logic [3:0]       cur_type, cur_type_next;
  logic [1:0]       hdr_left, hdr_left_next;
  logic [15:0]      pay_left, pay_left_next;
  logic [31:0]      acc, acc_next;
  logic             fault, fault_next;
  logic [STK_W-1:0] stk [MAX_NESTING];

  result_t res, res_next;
  logic    res_valid;
  logic    accept;

  logic [3:0]       fin_closed;
  logic [LVL_W-1:0] fin_level;
  logic             fin_dec_en;
  logic [IDX_W-1:0] fin_dec_idx;
  logic             going;

  type_info_t       ti;
  logic             bb_go;
  logic [3:0]       bb_t;
  logic [15:0]      bb_n;
  logic             do_fin;
  logic             push_en;
  logic [STK_W-1:0] push_val;
  logic [1:0]       err;
  logic [15:0]      ext_val;
  logic [1:0]       hdr_dec;
  logic [15:0]      pay_dec;

  assign accept        = byte_ch.valid && byte_ch.ready;
  assign byte_ch.ready = !res_valid || result_ch.ready;

  // count the levels that close when the current element finishes
  always_comb begin
    fin_closed  = 4'd1;
    fin_level   = stack_level;
    fin_dec_en  = 1'b0;
    fin_dec_idx = '0;
    going       = 1'b1;
    for (int i = MAX_NESTING - 1; i >= 0; i--) begin
      if (going && (LVL_W'(i) < stack_level)) begin
        if (stk[i] == STK_W'(1)) begin
          fin_closed = fin_closed + 4'd1;
          fin_level  = LVL_W'(i);
        end else begin
          going       = 1'b0;
          fin_dec_en  = 1'b1;
          fin_dec_idx = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    ti               = decode_type(byte_ch.data_byte);
    res_next         = '0;
    stack_level_next = stack_level;
    phase_next       = phase;
    cur_type_next    = cur_type;
    hdr_left_next    = hdr_left;
    pay_left_next    = pay_left;
    acc_next         = acc;
    fault_next       = fault;
    bb_go            = 1'b0;
    bb_t             = T_INVALID;
    bb_n             = '0;
    do_fin           = 1'b0;
    push_en          = 1'b0;
    push_val         = '0;
    err              = ERR_NONE;
    ext_val          = {acc[7:0], byte_ch.data_byte};
    hdr_dec          = hdr_left - 2'd1;
    pay_dec          = pay_left - 16'd1;

    if (fault) begin
      res_next.byte_role = ROLE_IGNORED;
    end else begin
      res_next.nest_depth = 4'(stack_level);
      unique case (phase)
        PH_TYPE: begin
          res_next.byte_role = ROLE_TYPE;
          res_next.elem_type = ti.t;
          if (!byte_ch.data_byte[7]) begin
            res_next.uint_value = {25'd0, byte_ch.data_byte[6:0]};
            res_next.uint_valid = 1'b1;
          end
          if (ti.t == T_INVALID) begin
            err = ERR_UNKNOWN;
          end else if (ti.ext != 2'd0) begin
            phase_next    = PH_EXT;
            hdr_left_next = ti.ext;
            acc_next      = '0;
            cur_type_next = ti.t;
          end else begin
            bb_go = 1'b1;
            bb_t  = ti.t;
            bb_n  = ti.n;
          end
        end
        PH_EXT: begin
          res_next.byte_role = ROLE_EXT;
          res_next.elem_type = cur_type;
          acc_next           = {16'd0, ext_val};
          hdr_left_next      = hdr_dec;
          if (hdr_dec == 2'd0) begin
            phase_next = PH_TYPE;
            bb_go      = 1'b1;
            bb_t       = cur_type;
            bb_n       = ext_val;
          end
        end
        default: begin
          res_next.byte_role  = ROLE_PAYLOAD;
          res_next.elem_type  = cur_type;
          res_next.elem_count = pay_left;
          acc_next            = {acc[23:0], byte_ch.data_byte};
          pay_left_next       = pay_dec;
          if (pay_dec == 16'd0) begin
            phase_next = PH_TYPE;
            do_fin     = 1'b1;
            if (cur_type == T_UINT) begin
              res_next.uint_value = {acc[23:0], byte_ch.data_byte};
              res_next.uint_valid = 1'b1;
            end
          end
        end
      endcase

      if (bb_go) begin
        res_next.header_done = 1'b1;
        res_next.elem_count  = bb_n;
        if ((bb_t == T_ARR) || (bb_t == T_MAP)) begin
          if (bb_n == 16'd0) begin
            do_fin = 1'b1;
          end else if (stack_level >= LVL_W'(MAX_NESTING)) begin
            err = ERR_DEEP;
          end else begin
            push_en  = 1'b1;
            push_val = (bb_t == T_MAP) ? {bb_n, 1'b0} : {1'b0, bb_n};
          end
        end else if (bb_n == 16'd0) begin
          do_fin = 1'b1;
        end else begin
          phase_next    = PH_PAY;
          pay_left_next = bb_n;
          acc_next      = '0;
          cur_type_next = bb_t;
        end
      end

      if (do_fin) begin
        res_next.levels_closed = fin_closed;
        stack_level_next       = fin_level;
      end
      if (push_en) begin
        stack_level_next = stack_level + LVL_W'(1);
      end
      res_next.message_done = do_fin && (stack_level_next == '0);

      if (byte_ch.last_byte && (err == ERR_NONE) &&
          !((phase_next == PH_TYPE) && (stack_level_next == '0))) begin
        err = ERR_TRUNC;
      end
      res_next.error_code = err;
      if (err != ERR_NONE) begin
        fault_next = 1'b1;
      end
    end

    if (byte_ch.last_byte) begin
      stack_level_next = '0;
      phase_next       = PH_TYPE;
      cur_type_next    = T_INVALID;
      hdr_left_next    = '0;
      pay_left_next    = '0;
      acc_next         = '0;
      fault_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_level <= '0;
      phase       <= PH_TYPE;
      cur_type    <= T_INVALID;
      hdr_left    <= '0;
      pay_left    <= '0;
      acc         <= '0;
      fault       <= 1'b0;
    end else if (accept) begin
      stack_level <= stack_level_next;
      phase       <= phase_next;
      cur_type    <= cur_type_next;
      hdr_left    <= hdr_left_next;
      pay_left    <= pay_left_next;
      acc         <= acc_next;
      fault       <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NESTING; i++) begin
      if (!rst && accept) begin
        if (push_en && (LVL_W'(i) == stack_level)) begin
          stk[i] <= push_val;
        end else if (do_fin && fin_dec_en && (IDX_W'(i) == fin_dec_idx)) begin
          stk[i] <= stk[i] - STK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result_ch.valid         = res_valid;
  assign result_ch.byte_role     = res.byte_role;
  assign result_ch.elem_type     = res.elem_type;
  assign result_ch.elem_count    = res.elem_count;
  assign result_ch.nest_depth    = res.nest_depth;
  assign result_ch.header_done   = res.header_done;
  assign result_ch.levels_closed = res.levels_closed;
  assign result_ch.uint_value    = res.uint_value;
  assign result_ch.uint_valid    = res.uint_valid;
  assign result_ch.error_code    = res.error_code;
  assign result_ch.message_done  = res.message_done;

  `MSW_ASSERT_RST(a_level_bound, rst || (stack_level <= LVL_W'(MAX_NESTING)),
    "stack level beyond nesting limit")
  `MSW_ASSERT(a_last_clears, accept && byte_ch.last_byte |=>
    (stack_level == '0) && (phase == PH_TYPE) && !fault, "state not cleared after last byte")
  `MSW_ASSERT(a_result_follows, accept |=> res_valid, "accepted request gave no result")
  `MSW_ASSERT(a_ignored_quiet, res_valid && (res.byte_role == ROLE_IGNORED) |->
    (res.error_code == ERR_NONE) && (res.levels_closed == 4'd0) && !res.message_done,
    "ignored byte carries status")
  `MSW_ASSERT(a_error_latches, accept && (res_next.error_code != ERR_NONE) &&
    !byte_ch.last_byte |=> fault, "error did not latch")

endmodule

// File: verif/msgpack_structure_walker_top_tb.sv
module msgpack_structure_walker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msw_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 600;
  localparam logic [7:0] CODE_RESERVED = 8'hC1;

  class walker_scoreboard;
    logic [STK_W-1:0] child_left [MAX_NESTING];
    logic [3:0]       lvl;
    logic [1:0]       phase;
    logic [3:0]       cur_type;
    logic [1:0]       ext_left;
    logic [15:0]      pay_left;
    logic [31:0]      acc;
    bit               faulted;
    result_t          cur;
    result_t          pending [$];
    int               mismatches;
    int               results_seen;
    int               done_count;
    int               uint_count;
    int               deepest;
    int               err_count [4];

    function new();
      clear();
    endfunction

    function void clear();
      lvl = '0;
      phase = PH_TYPE;
      cur_type = T_INVALID;
      ext_left = '0;
      pay_left = '0;
      acc = '0;
      faulted = 1'b0;
    endfunction

    function logic [3:0] close_elements();
      logic [3:0]       n;
      logic [STK_W-1:0] top;
      n = 4'd1;
      while (lvl > 0 && lvl <= MAX_NESTING) begin
        top = child_left[lvl - 1] - 1'b1;
        child_left[lvl - 1] = top;
        if (top != 0) break;
        lvl--;
        n++;
      end
      return n;
    endfunction

    function logic [1:0] open_body(logic [3:0] t, logic [15:0] n);
      if (t == T_ARR || t == T_MAP) begin
        if (n == 0) begin
          cur.levels_closed = close_elements();
          return ERR_NONE;
        end
        if (lvl >= MAX_NESTING) return ERR_DEEP;
        child_left[lvl] = (t == T_MAP) ? {n, 1'b0} : {1'b0, n};
        lvl++;
        return ERR_NONE;
      end
      if (n == 0) begin
        cur.levels_closed = close_elements();
        return ERR_NONE;
      end
      phase = PH_PAY;
      pay_left = n;
      acc = '0;
      cur_type = t;
      return ERR_NONE;
    endfunction

    function void note_request(logic [7:0] b, logic last);
      logic [3:0]  t;
      logic [15:0] n;
      logic [1:0]  ext;
      cur = '0;
      if (faulted) begin
        cur.byte_role = ROLE_IGNORED;
      end else begin
        cur.nest_depth = lvl;
        if (phase == PH_TYPE) begin
          t = T_INVALID;
          n = '0;
          ext = '0;
          cur.byte_role = ROLE_TYPE;
          if (!b[7]) begin
            t = T_UINT;
            cur.uint_value = {25'd0, b[6:0]};
            cur.uint_valid = 1'b1;
          end else if ((b & MASK_TOP3) == PFX_NEGFIX) begin
            t = T_INT;
          end else if ((b & MASK_TOP3) == PFX_FIXSTR) begin
            t = T_STR;
            n = {11'd0, b[4:0]};
          end else if ((b & MASK_TOP4) == PFX_FIXARR) begin
            t = T_ARR;
            n = {12'd0, b[3:0]};
          end else if ((b & MASK_TOP4) == PFX_FIXMAP) begin
            t = T_MAP;
            n = {12'd0, b[3:0]};
          end else begin
            case (b)
              CODE_NIL:     t = T_NIL;
              CODE_FALSE:   t = T_FALSE;
              CODE_TRUE:    t = T_TRUE;
              CODE_UINT8:   begin t = T_UINT; n = 16'd1; end
              CODE_UINT16:  begin t = T_UINT; n = 16'd2; end
              CODE_UINT32:  begin t = T_UINT; n = 16'd4; end
              CODE_INT8:    begin t = T_INT; n = 16'd1; end
              CODE_INT16:   begin t = T_INT; n = 16'd2; end
              CODE_INT32:   begin t = T_INT; n = 16'd4; end
              CODE_STR8, CODE_BIN8: begin t = T_STR; ext = 2'd1; end
              CODE_ARRAY16: begin t = T_ARR; ext = 2'd2; end
              CODE_MAP16:   begin t = T_MAP; ext = 2'd2; end
              default:      t = T_INVALID;
            endcase
          end
          cur.elem_type = t;
          if (t == T_INVALID) begin
            cur.error_code = ERR_UNKNOWN;
          end else if (ext != 0) begin
            phase = PH_EXT;
            ext_left = ext;
            acc = '0;
            cur_type = t;
          end else begin
            cur.header_done = 1'b1;
            cur.elem_count = n;
            cur.error_code = open_body(t, n);
          end
        end else if (phase == PH_EXT) begin
          cur.byte_role = ROLE_EXT;
          cur.elem_type = cur_type;
          acc = {16'd0, acc[7:0], b};
          ext_left--;
          if (ext_left == 0) begin
            cur.header_done = 1'b1;
            cur.elem_count = acc[15:0];
            phase = PH_TYPE;
            cur.error_code = open_body(cur_type, acc[15:0]);
          end
        end else begin
          cur.byte_role = ROLE_PAYLOAD;
          cur.elem_type = cur_type;
          cur.elem_count = pay_left;
          acc = {acc[23:0], b};
          pay_left--;
          if (pay_left == 0) begin
            phase = PH_TYPE;
            if (cur_type == T_UINT) begin
              cur.uint_value = acc;
              cur.uint_valid = 1'b1;
            end
            cur.levels_closed = close_elements();
          end
        end
        if (cur.levels_closed != 0 && lvl == 0) cur.message_done = 1'b1;
        if (last && cur.error_code == ERR_NONE && !(phase == PH_TYPE && lvl == 0))
          cur.error_code = ERR_TRUNC;
        if (cur.error_code != ERR_NONE) faulted = 1'b1;
      end
      if (last) clear();
      pending.push_back(cur);
    endfunction

    function string show(result_t r);
      return $sformatf({"role=%0d type=%0d count=%0d depth=%0d hdr=%0b closed=%0d ",
                        "uint=%0h/%0b err=%0d done=%0b"},
                       r.byte_role, r.elem_type, r.elem_count, r.nest_depth, r.header_done,
                       r.levels_closed, r.uint_value, r.uint_valid, r.error_code,
                       r.message_done);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs", results_seen);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
      err_count[exp.error_code]++;
      if (exp.message_done) done_count++;
      if (exp.uint_valid) uint_count++;
      if (exp.nest_depth > deepest) deepest = exp.nest_depth;
    endfunction
  endclass

  logic clk;
  logic rst;
  msw_in_if  byte_ch ();
  msw_out_if result_ch ();

  msgpack_structure_walker_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  walker_scoreboard sb = new();
  logic [7:0] msg_q [$];
  int sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_random(int n);
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int pick_count();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, 3);
  endfunction

  function automatic void gen_elem(int lvl);
    int k;
    int n;
    k = $urandom_range(0, 15);
    if ((lvl >= 3 || msg_q.size() > 150) && k > 10) k = $urandom_range(0, 10);
    case (k)
      0: msg_q.push_back(8'($urandom_range(0, 127)));
      1: msg_q.push_back(PFX_NEGFIX | 8'($urandom_range(0, 31)));
      2: begin
        n = $urandom_range(0, 2);
        msg_q.push_back(n == 0 ? CODE_NIL : (n == 1 ? CODE_FALSE : CODE_TRUE));
      end
      3: begin msg_q.push_back(CODE_UINT8); push_random(1); end
      4: begin msg_q.push_back(CODE_UINT16); push_random(2); end
      5: begin msg_q.push_back(CODE_UINT32); push_random(4); end
      6: begin
        n = $urandom_range(0, 2);
        msg_q.push_back(n == 0 ? CODE_INT8 : (n == 1 ? CODE_INT16 : CODE_INT32));
        push_random(n == 0 ? 1 : (n == 1 ? 2 : 4));
      end
      7, 8: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
        msg_q.push_back(PFX_FIXSTR | 8'(n));
        push_random(n);
      end
      9, 10: begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        msg_q.push_back(k == 9 ? CODE_STR8 : CODE_BIN8);
        msg_q.push_back(8'(n));
        push_random(n);
      end
      11, 12: begin
        n = pick_count();
        msg_q.push_back(PFX_FIXARR | 8'(n));
        repeat (n) gen_elem(lvl + 1);
      end
      13: begin
        n = pick_count();
        msg_q.push_back(PFX_FIXMAP | 8'(n));
        repeat (2 * n) gen_elem(lvl + 1);
      end
      default: begin
        n = $urandom_range(0, 3);
        msg_q.push_back(k == 14 ? CODE_ARRAY16 : CODE_MAP16);
        msg_q.push_back(8'd0);
        msg_q.push_back(8'(n));
        repeat (k == 14 ? n : 2 * n) gen_elem(lvl + 1);
      end
    endcase
  endfunction

  function automatic void gen_chain();
    int k;
    k = $urandom_range(1, MAX_NESTING + 1);
    repeat (k) begin
      if ($urandom_range(0, 3) == 0) begin
        msg_q.push_back(CODE_ARRAY16);
        msg_q.push_back(8'd0);
        msg_q.push_back(8'd1);
      end else begin
        msg_q.push_back(PFX_FIXARR | 8'd1);
      end
    end
    gen_elem(3);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= l;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sb.note_request(b, l);
    sent++;
  endtask

  task automatic send_buffer();
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1, steady);
    msg_q.delete();
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int n;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    msg_q = '{8'h7F, 8'h00, PFX_NEGFIX, 8'hFF, CODE_NIL, CODE_FALSE, CODE_TRUE};
    send_buffer();
    msg_q = '{CODE_UINT32, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    msg_q = '{PFX_FIXMAP | 8'd2, PFX_FIXSTR, CODE_STR8, 8'h00, CODE_BIN8, 8'h01, 8'hAA,
              PFX_FIXARR};
    send_buffer();
    msg_q = '{CODE_ARRAY16, 8'h00, 8'h01, CODE_INT8, 8'h80};
    send_buffer();
    msg_q = '{CODE_MAP16, 8'h00, 8'h00};
    send_buffer();
    msg_q = '{CODE_RESERVED, 8'h00};
    send_buffer();
    msg_q = '{PFX_FIXARR | 8'd2, 8'h01};
    send_buffer();
    wait_drained();

    n = sent + RANDOM_BYTES;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        gen_elem(0);
      end else if (r < 65) begin
        repeat ($urandom_range(2, 4)) gen_elem(1);
      end else if (r < 78) begin
        gen_chain();
      end else if (r < 89) begin
        gen_elem(0);
        if (msg_q.size() > 1) msg_q = msg_q[0:$urandom_range(0, msg_q.size() - 2)];
      end else begin
        push_random($urandom_range(1, 6));
      end
      send_buffer();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("sent %0d bytes, checked %0d results: %0d messages closed, %0d unsigned values, %s",
             sent, sb.results_seen, sb.done_count, sb.uint_count,
             $sformatf("deepest nesting %0d", sb.deepest));
    $display("errors seen: unknown code %0d, truncated %0d, too deep %0d; %0d mismatches",
             sb.err_count[ERR_UNKNOWN], sb.err_count[ERR_TRUNC], sb.err_count[ERR_DEEP],
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm > 0) begin
        calm--;
        result_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
        else hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.byte_role     = result_ch.byte_role;
      got.elem_type     = result_ch.elem_type;
      got.elem_count    = result_ch.elem_count;
      got.nest_depth    = result_ch.nest_depth;
      got.header_done   = result_ch.header_done;
      got.levels_closed = result_ch.levels_closed;
      got.uint_value    = result_ch.uint_value;
      got.uint_valid    = result_ch.uint_valid;
      got.error_code    = result_ch.error_code;
      got.message_done  = result_ch.message_done;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: msgpack_structure_walker_top.f
+incdir+hw/rtl
hw/rtl/msw_pkg.sv
hw/rtl/msw_stream_if.sv
hw/rtl/msgpack_structure_walker_top.sv
verif/msgpack_structure_walker_top_tb.sv
